FILE: design/accessory_event_notifier_top_macros.svh
// ----------------------------------------------------------------------------
// Accessory event notifier assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ACCESSORY_EVENT_NOTIFIER_TOP_MACROS_SVH
`define ACCESSORY_EVENT_NOTIFIER_TOP_MACROS_SVH

// Same-cycle implication.
`define AEN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define AEN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/aen_pkg.sv
// ----------------------------------------------------------------------------
// Accessory event notifier package
// Operation and status codes, field widths and the transaction structs.
// ----------------------------------------------------------------------------
package aen_pkg;

  localparam int MASK_W   = 32;
  localparam int OP_W     = 3;
  localparam int SLOT_W   = 3;
  localparam int TYPE_IDX_W = 5;
  localparam int STATUS_W = 2;

  typedef enum logic [OP_W-1:0] {
    AEN_OP_INSERT   = 3'd0,
    AEN_OP_REMOVE   = 3'd1,
    AEN_OP_OPEN     = 3'd2,
    AEN_OP_CLOSE    = 3'd3,
    AEN_OP_SET_INT  = 3'd4,
    AEN_OP_READ     = 3'd5,
    AEN_OP_QUERY    = 3'd6
  } aen_op_e;

  typedef enum logic [STATUS_W-1:0] {
    AEN_ST_OK    = 2'd0,
    AEN_ST_BUSY  = 2'd1,
    AEN_ST_EMPTY = 2'd2
  } aen_status_e;

  typedef struct packed {
    logic [OP_W-1:0]       op;
    logic [SLOT_W-1:0]     slot;
    logic [TYPE_IDX_W-1:0] accessory;
    logic [MASK_W-1:0]     mask_in;
  } aen_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [SLOT_W-1:0]     slot_granted;
    logic [TYPE_IDX_W-1:0] event_type;
    logic                  event_connected;
    logic                  device_connected;
    logic [MASK_W-1:0]     connected_mask;
    logic [MASK_W-1:0]     interest_out;
    logic                  pending;
  } aen_result_t;

endpackage

FILE: design/aen_in_stage.sv
// ----------------------------------------------------------------------------
// Accessory event notifier input stage
// Registers one accepted transaction and holds it until the engine takes it.
// ----------------------------------------------------------------------------
module aen_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  aen_pkg::aen_item_t item_i,
  input  logic              advance_i,
  output logic              valid_o,
  output aen_pkg::aen_item_t item_o
);

  logic              valid_q, valid_d;
  logic              accept;
  aen_pkg::aen_item_t item_q;

  assign in_stall_o = valid_q && !advance_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign valid_d    = accept || (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: design/aen_engine.sv
// ----------------------------------------------------------------------------
// Accessory event notifier engine
// Holds connected mask and slot state; computes one result per transaction.
// ----------------------------------------------------------------------------
module aen_engine #(
  parameter int NUM_SLOTS = 5,
  parameter int NUM_TYPES = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  aen_pkg::aen_item_t  item_i,
  output aen_pkg::aen_result_t result_o
);

  localparam int MW     = aen_pkg::MASK_W;
  localparam int TYPE_W = (NUM_TYPES < MW) ? NUM_TYPES : MW;

  logic [TYPE_W-1:0]    conn_q, conn_d;
  logic [NUM_SLOTS-1:0] in_use_q, in_use_d;
  logic [MW-1:0]        interest_q [NUM_SLOTS];
  logic [MW-1:0]        interest_d [NUM_SLOTS];
  logic [TYPE_W-1:0]    change_q [NUM_SLOTS];
  logic [TYPE_W-1:0]    change_d [NUM_SLOTS];

  logic                 is_ins, is_rem, is_open, is_close, is_set, is_read;
  logic                 type_ok, is_conn, fire;
  logic [TYPE_W-1:0]    type_bit;
  logic [NUM_SLOTS-1:0] free, free_oh, sel;
  logic                 open_ok, sel_use, read_ok;
  logic [TYPE_W-1:0]    change_sel, low_oh, change_out;
  logic [MW-1:0]        interest_out;
  logic [aen_pkg::SLOT_W-1:0]     granted;
  logic [aen_pkg::TYPE_IDX_W-1:0] ev_type;

  // Decode
  always_comb begin
    is_ins   = item_i.op == aen_pkg::AEN_OP_INSERT;
    is_rem   = item_i.op == aen_pkg::AEN_OP_REMOVE;
    is_open  = item_i.op == aen_pkg::AEN_OP_OPEN;
    is_close = item_i.op == aen_pkg::AEN_OP_CLOSE;
    is_set   = item_i.op == aen_pkg::AEN_OP_SET_INT;
    is_read  = item_i.op == aen_pkg::AEN_OP_READ;
    type_ok  = int'(item_i.accessory) < NUM_TYPES;
    type_bit = type_ok ? (TYPE_W'(1) << item_i.accessory) : '0;
    is_conn  = |(conn_q & type_bit);
    fire     = type_ok && ((is_ins && !is_conn) || (is_rem && is_conn));
    // lowest free slot as a one-hot
    free     = ~in_use_q;
    free_oh  = free & (~free + NUM_SLOTS'(1));
    open_ok  = is_open && (|free);
  end

  // Addressed slot and the pending set it shows before this transaction
  always_comb begin
    change_sel = '0;
    sel_use    = 1'b0;
    for (int k = 0; k < NUM_SLOTS; k++) begin
      sel[k]     = open_ok ? free_oh[k] : (int'(item_i.slot) == k);
      change_sel = change_sel | ({TYPE_W{sel[k]}} & change_q[k]);
      sel_use    = sel_use | (sel[k] && in_use_q[k]);
    end
    read_ok = is_read && sel_use && (|change_sel);
    low_oh  = change_sel & (~change_sel + TYPE_W'(1));
  end

  // Next state
  always_comb begin
    conn_d = fire ? (conn_q ^ type_bit) : conn_q;
    for (int k = 0; k < NUM_SLOTS; k++) begin
      in_use_d[k]   = in_use_q[k];
      interest_d[k] = interest_q[k];
      change_d[k]   = change_q[k];
      // toggle: clear if pending, else set if of interest
      if (fire && in_use_q[k]) begin
        change_d[k] = change_q[k] ^
                      (type_bit & (change_q[k] | interest_q[k][TYPE_W-1:0]));
      end
      if (open_ok && free_oh[k]) begin
        in_use_d[k]   = 1'b1;
        interest_d[k] = '1;
        change_d[k]   = '0;
      end
      if (is_close && sel[k]) begin
        in_use_d[k] = 1'b0;
      end
      if (is_set && sel[k] && in_use_q[k]) begin
        interest_d[k] = item_i.mask_in;
      end
      if (read_ok && sel[k]) begin
        change_d[k] = change_q[k] & ~low_oh;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conn_q   <= '0;
      in_use_q <= '0;
      for (int k = 0; k < NUM_SLOTS; k++) begin
        interest_q[k] <= '1;
        change_q[k]   <= '0;
      end
    end else if (advance_i) begin
      conn_q   <= conn_d;
      in_use_q <= in_use_d;
      for (int k = 0; k < NUM_SLOTS; k++) begin
        interest_q[k] <= interest_d[k];
        change_q[k]   <= change_d[k];
      end
    end
  end

  // Encode one-hots into indices; gather the addressed slot's interest and pending masks
  always_comb begin
    granted      = '0;
    interest_out = '0;
    change_out   = '0;
    for (int k = 0; k < NUM_SLOTS; k++) begin
      granted      = granted | ({aen_pkg::SLOT_W{open_ok && free_oh[k]}} &
                                aen_pkg::SLOT_W'(k));
      interest_out = interest_out | ({MW{sel[k]}} & interest_d[k]);
      change_out   = change_out | ({TYPE_W{sel[k]}} & change_d[k]);
    end
    ev_type = '0;
    for (int i = 0; i < TYPE_W; i++) begin
      ev_type = ev_type | ({aen_pkg::TYPE_IDX_W{read_ok && low_oh[i]}} &
                           aen_pkg::TYPE_IDX_W'(i));
    end
  end

  always_comb begin
    if (is_open && !open_ok) begin
      result_o.status = aen_pkg::AEN_ST_BUSY;
    end else if (is_read && !read_ok) begin
      result_o.status = aen_pkg::AEN_ST_EMPTY;
    end else begin
      result_o.status = aen_pkg::AEN_ST_OK;
    end
    result_o.slot_granted     = granted;
    result_o.event_type       = ev_type;
    result_o.event_connected  = read_ok && (|(conn_q & low_oh));
    result_o.device_connected = |(conn_d & type_bit);
    result_o.connected_mask   = MW'(conn_d);
    result_o.interest_out     = interest_out;
    result_o.pending          = |change_out;
  end

endmodule

FILE: design/aen_out_stage.sv
// ----------------------------------------------------------------------------
// Accessory event notifier output stage
// Result register; holds a result while the receiver stalls.
// ----------------------------------------------------------------------------
module aen_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 advance_i,
  input  aen_pkg::aen_result_t result_i,
  output logic                 ready_o,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output aen_pkg::aen_result_t result_o
);

  logic                 valid_q, valid_d;
  aen_pkg::aen_result_t result_q;

  assign ready_o = !valid_q || !out_stall_i;
  assign valid_d = advance_i || (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

FILE: design/accessory_event_notifier_top.sv
// ----------------------------------------------------------------------------
// Accessory event notifier
// Tracks connected accessory types and per-client pending change masks.
// ----------------------------------------------------------------------------
// Takes one transaction per clock cycle while not stalled and returns one
// result for each: a transaction waits in the input register, then the
// state update and result are formed in a single pass and land in the
// result register. State changes as a transaction moves into the result
// register, so results follow input order. A stall on the output backs up
// into in_stall_o once the input register is also full.
module accessory_event_notifier_top #(
  parameter int NUM_SLOTS = 5,
  parameter int NUM_TYPES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  op_i,
  input  logic [2:0]  slot_i,
  input  logic [4:0]  accessory_i,
  input  logic [31:0] mask_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [2:0]  slot_granted_o,
  output logic [4:0]  event_type_o,
  output logic        event_connected_o,
  output logic        device_connected_o,
  output logic [31:0] connected_mask_o,
  output logic [31:0] interest_out_o,
  output logic        pending_o
);

  aen_pkg::aen_item_t   item_in, item_s1;
  aen_pkg::aen_result_t result_d, result_q;
  logic                 s1_valid, out_ready, advance;

  assign item_in.op        = op_i;
  assign item_in.slot      = slot_i;
  assign item_in.accessory = accessory_i;
  assign item_in.mask_in   = mask_in_i;

  // advance the held transaction whenever the result register can take it
  assign advance = s1_valid && out_ready;

  aen_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (item_in),
    .advance_i  (advance),
    .valid_o    (s1_valid),
    .item_o     (item_s1)
  );

  aen_engine #(
    .NUM_SLOTS (NUM_SLOTS),
    .NUM_TYPES (NUM_TYPES)
  ) u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (item_s1),
    .result_o  (result_d)
  );

  aen_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .result_i    (result_d),
    .ready_o     (out_ready),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .result_o    (result_q)
  );

  assign status_o           = result_q.status;
  assign slot_granted_o     = result_q.slot_granted;
  assign event_type_o       = result_q.event_type;
  assign event_connected_o  = result_q.event_connected;
  assign device_connected_o = result_q.device_connected;
  assign connected_mask_o   = result_q.connected_mask;
  assign interest_out_o     = result_q.interest_out;
  assign pending_o          = result_q.pending;

endmodule

FILE: design/aen_checker.sv
// ----------------------------------------------------------------------------
// Accessory event notifier port checker
// Watches the result port over time; bound to the top level.
// ----------------------------------------------------------------------------
`include "accessory_event_notifier_top_macros.svh"

module aen_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  status_o,
  input logic [2:0]  slot_granted_o,
  input logic [4:0]  event_type_o,
  input logic        event_connected_o,
  input logic [31:0] connected_mask_o
);

  // a failed open grants nothing and pops nothing
  `AEN_ASSERT_NOW(a_busy_clean, out_valid_o && (status_o == aen_pkg::AEN_ST_BUSY), (slot_granted_o == 3'd0) && (event_type_o == 5'd0) && !event_connected_o, "busy result carries a grant or an event")
  // an empty read pops nothing
  `AEN_ASSERT_NOW(a_empty_clean, out_valid_o && (status_o == aen_pkg::AEN_ST_EMPTY), (event_type_o == 5'd0) && !event_connected_o, "empty read carries an event")
  // a connected event only comes with a successful transaction
  `AEN_ASSERT_NOW(a_evconn_ok, out_valid_o && event_connected_o, status_o == aen_pkg::AEN_ST_OK, "connected event with error status")
  // hold a stalled result
  `AEN_ASSERT_NEXT(a_stall_hold, out_valid_o && out_stall_i, out_valid_o && $stable(status_o) && $stable(connected_mask_o), "stalled result changed")

endmodule

bind accessory_event_notifier_top aen_checker u_aen_checker (.*);
